/* hdl/mdu_pkg.sv */
package mdu_pkg;

   localparam int XLEN = 64;

   typedef enum logic [2:0] {
      OP_MUL    = 3'd0,
      OP_MULH   = 3'd1,
      OP_MULHSU = 3'd2,
      OP_MULHU  = 3'd3,
      OP_DIV    = 3'd4,
      OP_DIVU   = 3'd5,
      OP_REM    = 3'd6,
      OP_REMU   = 3'd7
   } op_type;

   localparam logic [6:0] GROUP_M = 7'd1;

   // one beat in flight through the divide array
   typedef struct packed {
      logic            valid;
      logic            illegal;
      logic [4:0]      dest;
      logic            is_div;
      logic            sel_rem;
      logic            neg;
      logic [XLEN-1:0] rem;
      logic [XLEN-1:0] quo;
      logic [XLEN-1:0] dvs;
   } stage_type;

endpackage

/* hdl/mdu_div_stage.sv */
module mdu_div_stage
   import mdu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  stage_type prev_stage,
   output stage_type stage_out
);

   stage_type       stage_ff;
   stage_type       stage_in;
   logic [XLEN:0]   trial;
   logic [XLEN:0]   diff;
   logic            fits;

   always_comb begin
      trial    = {prev_stage.rem, prev_stage.quo[XLEN-1]};
      diff     = trial - {1'b0, prev_stage.dvs};
      // no borrow means the divisor fits
      fits     = !diff[XLEN];
      stage_in = prev_stage;
      if (prev_stage.is_div) begin
         stage_in.rem = fits ? diff[XLEN-1:0] : trial[XLEN-1:0];
         stage_in.quo = {prev_stage.quo[XLEN-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

/* hdl/rv64m_multiply_divide_unit.sv */
// RV64M multiply/divide execute unit.
// req channel: one instruction per beat (funct3 in req_cmd, funct7 in
// req_func_group, rd and both source values). rsp channel: one result per
// beat with the 64-bit value, rd passed through and an illegal flag.
// Fully pipelined: a beat may be accepted in every cycle that req_stall is
// low. A result reaches rsp through the input register, two multiplier
// stages (32x32 partial products, then the 128-bit sum and sign fix), 64
// one-bit restoring divide stages, and the output register.
// Multiply beats ride through the divide stages unchanged, so results come
// out in request order for every mix of operations.
// Reset clears all valid bits; no result is pending afterwards.
// When rsp_stall is high with a result waiting, the whole pipeline holds
// and req_stall rises in the same cycle; nothing is lost or repeated.
// Illegal funct7 gives rsp_illegal high and a zero result.
module rv64m_multiply_divide_unit
   import mdu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [6:0]  req_func_group,
   input  logic [4:0]  req_dest_index,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_value,
   output logic [4:0]  rsp_result_dest,
   output logic        rsp_illegal
);

   typedef struct packed {
      logic            valid;
      logic            illegal;
      op_type          op;
      logic [4:0]      dest;
      logic [63:0]     pp_ll;
      logic [63:0]     pp_lh;
      logic [63:0]     pp_hl;
      logic [63:0]     pp_hh;
      logic [XLEN-1:0] corr;
      logic            special;
      logic [XLEN-1:0] special_val;
      logic            sel_rem;
      logic            neg;
      logic [XLEN-1:0] divd;
      logic [XLEN-1:0] dvs;
   } mul1_type;

   typedef struct packed {
      logic            valid;
      logic            illegal;
      op_type          op;
      logic [4:0]      dest;
      logic [127:0]    prod;
      logic [XLEN-1:0] corr;
      logic            special;
      logic [XLEN-1:0] special_val;
      logic            sel_rem;
      logic            neg;
      logic [XLEN-1:0] divd;
      logic [XLEN-1:0] dvs;
   } mul2_type;

   logic            enable;

   logic            s0_valid_ff;
   logic            s0_illegal_ff;
   op_type          s0_op_ff;
   logic [4:0]      s0_dest_ff;
   logic [XLEN-1:0] s0_a_ff;
   logic [XLEN-1:0] s0_b_ff;

   mul1_type        p1_ff;
   mul1_type        p1_in;
   mul2_type        p2_ff;
   mul2_type        p2_in;

   logic            is_signed_div;
   logic            neg_a;
   logic            neg_b;
   logic            is_rem_op;
   logic            b_zero;
   logic            overflow;

   stage_type       div_init;
   stage_type       div_chain [XLEN+1];
   logic [XLEN-1:0] mul_res;
   logic [XLEN-1:0] fin_val;

   logic            rsp_valid_ff;
   logic [63:0]     rsp_value_ff;
   logic [63:0]     rsp_value_in;
   logic [4:0]      rsp_dest_ff;
   logic            rsp_illegal_ff;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (enable) begin
         s0_valid_ff   <= req_valid;
         s0_illegal_ff <= (req_func_group != GROUP_M);
         s0_op_ff      <= op_type'(req_cmd);
         s0_dest_ff    <= req_dest_index;
         s0_a_ff       <= req_operand_a;
         s0_b_ff       <= req_operand_b;
      end
   end

   // operand prep: partial products, sign correction, divide setup
   always_comb begin
      is_signed_div = (s0_op_ff == OP_DIV) || (s0_op_ff == OP_REM);
      is_rem_op     = (s0_op_ff == OP_REM) || (s0_op_ff == OP_REMU);
      neg_a         = is_signed_div && s0_a_ff[XLEN-1];
      neg_b         = is_signed_div && s0_b_ff[XLEN-1];
      b_zero        = (s0_b_ff == '0);
      overflow      = is_signed_div && (s0_a_ff == {1'b1, {(XLEN-1){1'b0}}})
                      && (s0_b_ff == '1);

      p1_in.valid   = s0_valid_ff;
      p1_in.illegal = s0_illegal_ff;
      p1_in.op      = s0_op_ff;
      p1_in.dest    = s0_dest_ff;
      p1_in.pp_ll   = s0_a_ff[31:0]  * s0_b_ff[31:0];
      p1_in.pp_lh   = s0_a_ff[31:0]  * s0_b_ff[63:32];
      p1_in.pp_hl   = s0_a_ff[63:32] * s0_b_ff[31:0];
      p1_in.pp_hh   = s0_a_ff[63:32] * s0_b_ff[63:32];

      case (s0_op_ff)
         OP_MULH: begin
            p1_in.corr = (s0_a_ff[XLEN-1] ? s0_b_ff : '0)
                       + (s0_b_ff[XLEN-1] ? s0_a_ff : '0);
         end
         OP_MULHSU: begin
            p1_in.corr = s0_a_ff[XLEN-1] ? s0_b_ff : '0;
         end
         default: begin
            p1_in.corr = '0;
         end
      endcase

      p1_in.special = b_zero || overflow;
      if (b_zero) begin
         p1_in.special_val = is_rem_op ? s0_a_ff : '1;
      end else begin
         p1_in.special_val = is_rem_op ? '0 : s0_a_ff;
      end
      p1_in.sel_rem = is_rem_op;
      p1_in.neg     = is_rem_op ? neg_a : (neg_a ^ neg_b);
      p1_in.divd    = neg_a ? (XLEN'(0) - s0_a_ff) : s0_a_ff;
      p1_in.dvs     = neg_b ? (XLEN'(0) - s0_b_ff) : s0_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.valid <= 1'b0;
      end else if (enable) begin
         p1_ff <= p1_in;
      end
   end

   always_comb begin
      p2_in.valid       = p1_ff.valid;
      p2_in.illegal     = p1_ff.illegal;
      p2_in.op          = p1_ff.op;
      p2_in.dest        = p1_ff.dest;
      p2_in.prod        = {p1_ff.pp_hh, 64'd0}
                        + {32'd0, p1_ff.pp_lh, 32'd0}
                        + {32'd0, p1_ff.pp_hl, 32'd0}
                        + {64'd0, p1_ff.pp_ll};
      p2_in.corr        = p1_ff.corr;
      p2_in.special     = p1_ff.special;
      p2_in.special_val = p1_ff.special_val;
      p2_in.sel_rem     = p1_ff.sel_rem;
      p2_in.neg         = p1_ff.neg;
      p2_in.divd        = p1_ff.divd;
      p2_in.dvs         = p1_ff.dvs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ff.valid <= 1'b0;
      end else if (enable) begin
         p2_ff <= p2_in;
      end
   end

   // finish multiply, load the divide array
   always_comb begin
      if (p2_ff.op == OP_MUL) begin
         mul_res = p2_ff.prod[XLEN-1:0];
      end else begin
         mul_res = p2_ff.prod[2*XLEN-1:XLEN] - p2_ff.corr;
      end

      div_init.valid   = p2_ff.valid;
      div_init.illegal = p2_ff.illegal;
      div_init.dest    = p2_ff.dest;
      div_init.is_div  = 1'b0;
      div_init.sel_rem = p2_ff.sel_rem;
      div_init.neg     = p2_ff.neg;
      div_init.rem     = '0;
      div_init.quo     = mul_res;
      div_init.dvs     = p2_ff.dvs;
      if (p2_ff.illegal) begin
         div_init.quo = '0;
      end else if (p2_ff.op[2]) begin
         if (p2_ff.special) begin
            div_init.quo = p2_ff.special_val;
         end else begin
            div_init.is_div = 1'b1;
            div_init.quo    = p2_ff.divd;
         end
      end
   end

   assign div_chain[0] = div_init;

   for (genvar i = 0; i < XLEN; i++) begin : g_div
      mdu_div_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .prev_stage (div_chain[i]),
         .stage_out  (div_chain[i+1])
      );
   end

   always_comb begin
      fin_val = div_chain[XLEN].sel_rem ? div_chain[XLEN].rem
                                        : div_chain[XLEN].quo;
      if (div_chain[XLEN].is_div) begin
         rsp_value_in = div_chain[XLEN].neg ? (XLEN'(0) - fin_val) : fin_val;
      end else begin
         rsp_value_in = div_chain[XLEN].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff   <= div_chain[XLEN].valid;
         rsp_value_ff   <= rsp_value_in;
         rsp_dest_ff    <= div_chain[XLEN].dest;
         rsp_illegal_ff <= div_chain[XLEN].illegal;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_dest  = rsp_dest_ff;
   assign rsp_illegal      = rsp_illegal_ff;

endmodule

/* hdl/mdu_checker.sv */
module mdu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_result_value,
   input logic [4:0]  rsp_result_dest,
   input logic        rsp_illegal
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side holds exactly when a waiting result is stalled
   a_stall_link: assert property (@(posedge clock)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output stall");

   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_illegal) |-> (rsp_result_value == 64'd0))
      else $error("illegal beat with nonzero result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_result_value) && $stable(rsp_result_dest)))
      else $error("stalled result changed");

endmodule

bind rv64m_multiply_divide_unit mdu_checker u_mdu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value),
   .rsp_result_dest  (rsp_result_dest),
   .rsp_illegal      (rsp_illegal)
);
